@@ rtl/wlm_pkg.sv @@
// shared types and constants of the word length masker
`default_nettype none
package wlm_pkg;

  localparam int unsigned CNT_W   = 6;
  localparam int unsigned ADDR_W  = 6;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned Q_DEPTH = 2;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_rsp_t;

  // one input byte's worth of output work
  typedef struct packed {
    logic [7:0]       data;
    logic             has_byte;
    logic             blank;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_FLUSH,
    BK_BYTE
  } back_state_e;

endpackage
`default_nettype wire

@@ rtl/wlm_front.sv @@
// front end: classifies bytes, tracks the held word, issues output commands
`default_nettype none
module wlm_front #(
  parameter int unsigned MAX_WORD = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire wlm_pkg::in_req_t           in_req_i,
  output logic                            in_stall_o,
  input  wire logic [wlm_pkg::CFG_W-1:0]  target_i,
  output logic                            push_o,
  output wlm_pkg::cmd_t                   cmd_o,
  input  wire logic                       q_full_i,
  input  wire logic                       flush_done_i,
  output wlm_pkg::store_wr_t              wr_o
);
  import wlm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WORD + 1);

  logic [CW-1:0] held_q, held_d;
  logic          pt_q, pt_d;
  logic          pend_q, pend_d;
  logic [CW:0]   held_inc;
  logic [6:0]    tgt_ext;
  logic          accept, is_delim, full;
  cmd_t          cmd;
  logic          wr_en;

  assign in_stall_o = pend_q || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_delim   = (in_req_i.in_byte == CH_SPACE) || (in_req_i.in_byte == CH_NEWLINE);
  assign held_inc   = {1'b0, held_q} + {{CW{1'b0}}, 1'b1};
  assign tgt_ext    = {1'b0, target_i};
  assign full       = (held_q == CW'(MAX_WORD));

  always_comb begin
    cmd          = '0;
    cmd.data     = in_req_i.in_byte;
    held_d       = held_q;
    pt_d         = pt_q;
    wr_en        = 1'b0;
    if (is_delim) begin
      cmd.cnt      = pt_q ? '0 : CNT_W'(held_q);
      cmd.blank    = (7'(held_q) == tgt_ext);
      cmd.has_byte = 1'b1;
      held_d       = '0;
      pt_d         = 1'b0;
    end else if (pt_q) begin
      cmd.has_byte = 1'b1;
    end else if (full) begin
      cmd.cnt      = CNT_W'(held_q);
      cmd.has_byte = 1'b1;
      held_d       = '0;
      pt_d         = 1'b1;
    end else begin
      wr_en = 1'b1;
      if (7'(held_inc) > tgt_ext) begin
        // word outgrew the target: flush it unchanged
        cmd.cnt = CNT_W'(held_inc);
        held_d  = '0;
        pt_d    = 1'b1;
      end else if (in_req_i.stream_end) begin
        cmd.cnt   = CNT_W'(held_inc);
        cmd.blank = (7'(held_inc) == tgt_ext);
      end else begin
        held_d = CW'(held_inc);
      end
    end
    if (in_req_i.stream_end) begin
      held_d = '0;
      pt_d   = 1'b0;
    end
  end

  assign cmd_o   = cmd;
  assign push_o  = accept && ((cmd.cnt != '0) || cmd.has_byte);
  // one flush in flight at a time so the store is not overwritten early
  assign pend_d  = (pend_q && !flush_done_i) || (push_o && (cmd.cnt != '0));

  always_comb begin
    wr_o      = '0;
    wr_o.we   = accept && wr_en;
    wr_o.addr = ADDR_W'(held_q);
    wr_o.data = in_req_i.in_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pt_q   <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (accept) begin
        held_q <= held_d;
        pt_q   <= pt_d;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/wlm_cmd_fifo.sv @@
// two-entry command queue between front and back end
`default_nettype none
module wlm_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire wlm_pkg::cmd_t  cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output wlm_pkg::cmd_t       cmd_o,
  output logic                empty_o
);
  import wlm_pkg::*;

  localparam int unsigned QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(Q_DEPTH + 1);

  cmd_t           entry_q [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == QCW'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/wlm_back.sv @@
// back end: word store, flush sequencer and output register
`default_nettype none
module wlm_back #(
  parameter int unsigned MAX_WORD = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wlm_pkg::store_wr_t  wr_i,
  input  wire logic                q_empty_i,
  input  wire wlm_pkg::cmd_t       q_cmd_i,
  output logic                     pop_o,
  output logic                     flush_done_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output wlm_pkg::out_rsp_t        out_rsp_o
);
  import wlm_pkg::*;

  localparam int unsigned AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  logic [7:0]       store [MAX_WORD];
  back_state_e      state_q, state_d;
  cmd_t             cmd_q;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [7:0]       rd_q;
  out_rsp_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free, last_flush, load;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign last_flush = ((idx_q + CNT_W'(1)) == cmd_q.cnt);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = (q_cmd_i.cnt != '0) ? BK_READ : BK_BYTE;
        end
      end
      BK_READ: begin
        state_d = BK_FLUSH;
      end
      BK_FLUSH: begin
        if (slot_free) begin
          if (!last_flush) begin
            state_d = BK_READ;
          end else if (cmd_q.has_byte) begin
            state_d = BK_BYTE;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      BK_BYTE: begin
        if (slot_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o        = 1'b0;
    flush_done_o = 1'b0;
    load         = 1'b0;
    idx_d        = idx_q;
    out_d        = out_q;
    unique case (state_q)
      BK_IDLE: begin
        pop_o = !q_empty_i;
        idx_d = '0;
      end
      BK_READ: begin
        idx_d = idx_q;
      end
      BK_FLUSH: begin
        if (slot_free) begin
          load           = 1'b1;
          out_d.out_byte = cmd_q.blank ? CH_SPACE : rd_q;
          out_d.run_last = last_flush && !cmd_q.has_byte;
          idx_d          = idx_q + CNT_W'(1);
          flush_done_o   = last_flush;
        end
      end
      BK_BYTE: begin
        if (slot_free) begin
          load           = 1'b1;
          out_d.out_byte = cmd_q.data;
          out_d.run_last = 1'b1;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      store[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
    if (state_q == BK_READ) begin
      rd_q <= store[idx_q[AW-1:0]];
    end
    if (pop_o) begin
      cmd_q <= q_cmd_i;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/word_length_masker.sv @@
// word length masker top level: blanks every word of the configured length
//
// input channel: in_valid_i / in_stall_o carry one text byte and a stream end
// flag per request. output channel: out_valid_o / out_stall_i carry one byte
// per request, run_last marks the final byte caused by an input request.
// config channel: cfg_valid_i / cfg_ready_o writes target_length; write it
// only while the block is idle. target_length of zero passes text unchanged.
// a word character that is only held gives no output request.
// a byte passed straight through is registered in the command queue, the
// command register and the output register. a held word drains one byte at a
// time through the one store read port (read then emit), followed by the delimiter.
// throughput: the back end handles one request at a time, a pass-through
// request through the idle and byte states; the front takes one byte per cycle,
// while not stalled, into a two-entry command queue. after a byte that starts a
// flush it stalls until the back end has read the whole held word from the store.
// reset clears the held count, the pass-through flag, the queue and the
// output valid flag, and sets target_length to zero. the store is not cleared.
// while the receiver stalls, the output register holds its request and the
// queue fills, after which in_stall_o rises.
`default_nettype none
module word_length_masker #(
  parameter int unsigned MAX_WORD = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire wlm_pkg::in_req_t           in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output wlm_pkg::out_rsp_t               out_rsp_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [wlm_pkg::CFG_W-1:0]  cfg_data_i
);
  import wlm_pkg::*;

  logic [CFG_W-1:0] target_q;
  logic             push, q_full, q_empty, pop, flush_done;
  cmd_t             push_cmd, head_cmd;
  store_wr_t        store_wr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  wlm_front #(
    .MAX_WORD(MAX_WORD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .target_i    (target_q),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .q_full_i    (q_full),
    .flush_done_i(flush_done),
    .wr_o        (store_wr)
  );

  wlm_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .empty_o(q_empty)
  );

  wlm_back #(
    .MAX_WORD(MAX_WORD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (store_wr),
    .q_empty_i   (q_empty),
    .q_cmd_i     (head_cmd),
    .pop_o       (pop),
    .flush_done_o(flush_done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire

@@ tb/word_length_masker_tb.sv @@
// testbench of the word length masker: scoreboard class, directed and random text streams
`default_nettype none
module word_length_masker_tb;
  import wlm_pkg::*;

  localparam int unsigned MAX_WORD     = 32;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned MAX_PRINTED  = 40;
  localparam int unsigned NUM_PHASES   = 9;

  class masker_scoreboard;
    logic [7:0]  word_buf [MAX_WORD];
    int unsigned held_len;
    bit          passing;
    int unsigned blank_len;
    out_rsp_t    expected_q [$];
    int unsigned errors;
    int unsigned bytes_in;
    int unsigned bytes_out;

    function new();
      held_len  = 0;
      passing   = 1'b0;
      blank_len = 0;
      errors    = 0;
      bytes_in  = 0;
      bytes_out = 0;
    endfunction

    function void set_target(logic [CFG_W-1:0] len);
      blank_len = len;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // works out every output byte caused by one accepted request
    function void note_request(in_req_t req);
      logic [7:0] produced [$];
      logic [7:0] b;
      bit         delim;
      b     = req.in_byte;
      delim = (b == CH_SPACE) || (b == CH_NEWLINE);
      bytes_in++;
      if (delim) begin
        if (!passing) begin
          for (int i = 0; i < held_len; i++)
            produced.push_back((held_len == blank_len) ? CH_SPACE : word_buf[i]);
          held_len = 0;
        end
        passing = 1'b0;
        produced.push_back(b);
      end else if (passing) begin
        produced.push_back(b);
      end else if (held_len >= MAX_WORD) begin
        // word outgrew the buffer: release it unchanged and pass the rest
        for (int i = 0; i < held_len; i++) produced.push_back(word_buf[i]);
        held_len = 0;
        produced.push_back(b);
        passing = 1'b1;
      end else begin
        word_buf[held_len] = b;
        held_len++;
        if (held_len > blank_len) begin
          for (int i = 0; i < held_len; i++) produced.push_back(word_buf[i]);
          held_len = 0;
          passing  = 1'b1;
        end
      end
      if (req.stream_end) begin
        for (int i = 0; i < held_len; i++)
          produced.push_back((held_len == blank_len) ? CH_SPACE : word_buf[i]);
        held_len = 0;
        passing  = 1'b0;
      end
      foreach (produced[i]) begin
        out_rsp_t rsp;
        rsp.out_byte = produced[i];
        rsp.run_last = (i == produced.size() - 1);
        expected_q.push_back(rsp);
      end
    endfunction

    task report(string what);
      // keep the log short when the block is badly off
      if (errors < MAX_PRINTED) $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(out_rsp_t got);
      out_rsp_t want;
      bytes_out++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected output byte %02h run_last %0b", got.out_byte,
                         got.run_last));
      end else begin
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("output %0d: out_byte %02h, expected %02h", bytes_out,
                           got.out_byte, want.out_byte));
        if (got.run_last !== want.run_last)
          report($sformatf("output %0d: run_last %0b, expected %0b", bytes_out,
                           got.run_last, want.run_last));
      end
    endtask

    task flag_leftovers();
      while (expected_q.size() != 0) begin
        report($sformatf("output byte %02h never arrived", expected_q[0].out_byte));
        void'(expected_q.pop_front());
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_req_t          in_req_i    = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_rsp_t         out_rsp_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  masker_scoreboard sb = new();
  int unsigned      tx_idle_pct = 22;
  int unsigned      rx_idle_pct = 86;
  bit               rx_hold_req = 1'b0;
  int unsigned      quiet_cycles = 0;
  int unsigned      cfg_writes = 0;

  word_length_masker #(
    .MAX_WORD (MAX_WORD)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_target(cfg_data_i);
        cfg_writes++;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("** word_length_masker: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task send_byte(logic [7:0] b, bit last);
    // sender idles cycle by cycle before offering the next request
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_req_i.in_byte    <= b;
    in_req_i.stream_end <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_SPACE || c == CH_NEWLINE);
    return c;
  endfunction

  function logic [7:0] delimiter();
    return $urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE;
  endfunction

  // stop offering and wait until every expected byte has come out
  task settle();
    in_valid_i <= 1'b0;
    // let the monitor note the last accepted request first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task write_target(logic [CFG_W-1:0] len);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // words with lengths around the target, some longer than the buffer
  task send_text(int unsigned budget, int unsigned tgt);
    int unsigned sent;
    int unsigned wlen;
    int unsigned pick;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2 && tgt >= 1 && tgt <= MAX_WORD) wlen = tgt;
      else if (pick == 3) wlen = tgt + 1;
      else if (pick == 4 && tgt >= 2) wlen = tgt - 1;
      else if (pick == 5) wlen = $urandom_range(MAX_WORD - 2, MAX_WORD + 2);
      else wlen = $urandom_range(1, 6);
      if (wlen > MAX_WORD + 2) wlen = $urandom_range(1, 6);
      // broken streams: an end flag may land anywhere
      for (int k = 0; k < wlen; k++) begin
        send_byte(word_char(), $urandom_range(0, 39) == 0);
        sent++;
      end
      repeat ($urandom_range(1, 2)) begin
        send_byte(delimiter(), $urandom_range(0, 39) == 0);
        sent++;
      end
    end
    send_byte(delimiter(), 1'b1);
  endtask

  initial begin
    logic [CFG_W-1:0] targets [NUM_PHASES];
    targets = '{6'd0, 6'd1, 6'd5, 6'd32, 6'd63, 6'd0, 6'd2, 6'd0, 6'd33};
    targets[5] = CFG_W'($urandom_range(3, 31));
    targets[7] = CFG_W'($urandom_range(3, 31));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_target(6'd3);
    // exact match, match with odd bytes, too long, too short, lone delimiter
    send_byte("a", 0); send_byte("b", 0); send_byte("c", 0); send_byte(CH_SPACE, 0);
    send_byte(8'h00, 0); send_byte(8'hFF, 0); send_byte("x", 0); send_byte(CH_NEWLINE, 0);
    send_byte("q", 0); send_byte("r", 0); send_byte("s", 0); send_byte("t", 0);
    send_byte(CH_SPACE, 0);
    send_byte("u", 0); send_byte("v", 0); send_byte(CH_SPACE, 0);
    send_byte(CH_NEWLINE, 0);
    // match closed by the end of the stream, then a short word and a delimiter end
    send_byte("w", 0); send_byte("y", 0); send_byte("z", 1);
    send_byte("k", 0); send_byte(CH_SPACE, 1);
    send_byte(CH_SPACE, 1);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 3) begin
        tx_idle_pct = 86;
        rx_idle_pct = 22;
      end else if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
      end
      write_target(targets[p]);
      send_text((targets[p] >= MAX_WORD) ? 56 : 38, targets[p]);
      settle();
    end

    sb.flag_leftovers();
    $display("run covered %0d input bytes and %0d output bytes over %0d target settings",
             sb.bytes_in, sb.bytes_out, cfg_writes);
    $display("targets included zero, one, the buffer size, above it, and the largest value");
    if (sb.errors == 0) begin
      $display("** word_length_masker: PASSED **");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("** word_length_masker: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/wlm_pkg.sv
rtl/wlm_front.sv
rtl/wlm_cmd_fifo.sv
rtl/wlm_back.sv
rtl/word_length_masker.sv
tb/word_length_masker_tb.sv
